### rtl/link_setup_teardown_sender_defines.svh
// Assertion macros used by the checker file.
`ifndef LINK_SETUP_TEARDOWN_SENDER_DEFINES_SVH
`define LINK_SETUP_TEARDOWN_SENDER_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define LSTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LSTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lsts_pkg.sv
package lsts_pkg;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_AWAIT_UA   = 2'd1,
    PH_AWAIT_DISC = 2'd2,
    PH_DONE       = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_RX    = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

  localparam logic [7:0] FLAG_BYTE       = 8'h7e;
  localparam logic [7:0] ADDR_RCV_TO_SND = 8'h01;
  localparam logic [7:0] ADDR_SND_TO_RCV = 8'h03;
  localparam logic [7:0] CTRL_SET        = 8'h03;
  localparam logic [7:0] CTRL_UA         = 8'h07;
  localparam logic [7:0] CTRL_DISC       = 8'h0b;

  localparam int unsigned FRAME_LEN = 5;
  localparam int unsigned IDX_W     = 3;

  localparam logic [2:0]  BODY_LEN      = 3'd3;
  localparam logic [2:0]  BODY_MAX      = 3'd7;
  localparam logic [15:0] TIMEOUT_RESET = 16'd3;

  typedef struct packed {
    logic       is_frame;
    logic [7:0] addr;
    logic [7:0] ctrl;
    phase_t     phase;
  } tx_job_t;

endpackage

### rtl/lsts_if.sv
interface lsts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface lsts_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       last;
  logic [1:0] phase;

  modport source (output valid, output tx_valid, output tx_byte, output last,
                  output phase, input ready);
  modport sink (input valid, input tx_valid, input tx_byte, input last,
                input phase, output ready);
endinterface

interface lsts_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ticks;

  modport source (output valid, output timeout_ticks, input ready);
  modport sink (input valid, input timeout_ticks, output ready);
endinterface

### rtl/link_setup_teardown_sender.sv
// Channel  | Direction | Payload
// item     | in        | mode, rx_byte
// result   | out       | tx_valid, tx_byte, last, phase
// cfg      | in        | timeout_ticks
//
// An item is decoded in the cycle of its transfer and its results are queued
// in the result register of the frame transmitter.
// A frame is 5 results, any other item a single one; the next item is taken in
// the cycle the last result of the previous one transfers.
// A stall on result holds the current byte and blocks item.
// rst is synchronous: idle phase, flag hunt, timer cleared, timeout_ticks 3.
module link_setup_teardown_sender
  import lsts_pkg::*;
(
  input logic clk,
  input logic rst,
  lsts_in_if.sink     item,
  lsts_out_if.source  result,
  lsts_cfg_if.sink    cfg
);

  phase_t      phase, phase_next;
  logic        in_frame, in_frame_next;
  logic [2:0]  body_count, body_count_next;
  logic [7:0]  rx_address, rx_address_next;
  logic [7:0]  rx_control, rx_control_next;
  logic [7:0]  rx_check, rx_check_next;
  logic [15:0] wait_count, wait_count_next;
  logic [15:0] timeout_ticks;

  logic        take;
  logic        accept;
  logic        waiting;
  logic        is_flag;
  logic [15:0] wait_inc;
  logic [15:0] limit;
  logic        timed_out;
  logic        ok_ua;
  logic        ok_disc;
  logic        send;
  tx_job_t     job;

  assign accept    = item.valid && take;
  assign item.ready = take;
  assign cfg.ready = 1'b1;

  assign waiting   = (phase == PH_AWAIT_UA) || (phase == PH_AWAIT_DISC);
  assign is_flag   = (item.rx_byte == FLAG_BYTE);
  assign wait_inc  = (wait_count == 16'hffff) ? wait_count : wait_count + 16'd1;
  assign limit     = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
  assign timed_out = (wait_inc >= limit);

  assign ok_ua   = (body_count == BODY_LEN) && (rx_address == ADDR_SND_TO_RCV) &&
                   (rx_control == CTRL_UA) && (rx_check == (ADDR_SND_TO_RCV ^ CTRL_UA));
  assign ok_disc = (body_count == BODY_LEN) && (rx_address == ADDR_SND_TO_RCV) &&
                   (rx_control == CTRL_DISC) &&
                   (rx_check == (ADDR_SND_TO_RCV ^ CTRL_DISC));

  always_comb begin
    phase_next      = phase;
    in_frame_next   = in_frame;
    body_count_next = body_count;
    rx_address_next = rx_address;
    rx_control_next = rx_control;
    rx_check_next   = rx_check;
    wait_count_next = wait_count;
    case (mode_t'(item.mode))
      MODE_START: begin
        if (!waiting) begin
          phase_next      = PH_AWAIT_UA;
          in_frame_next   = 1'b0;
          body_count_next = 3'd0;
          wait_count_next = 16'd0;
        end
      end
      MODE_RX: begin
        if (!in_frame) begin
          if (is_flag) begin
            in_frame_next   = 1'b1;
            body_count_next = 3'd0;
          end
        end else if (!is_flag) begin
          case (body_count)
            3'd0:    rx_address_next = item.rx_byte;
            3'd1:    rx_control_next = item.rx_byte;
            3'd2:    rx_check_next   = item.rx_byte;
            default: ;
          endcase
          if (body_count != BODY_MAX) begin
            body_count_next = body_count + 3'd1;
          end
        end else begin
          in_frame_next = 1'b0;
          if (waiting) begin
            wait_count_next = 16'd0;
          end
          if (phase == PH_AWAIT_UA && ok_ua) begin
            phase_next = PH_AWAIT_DISC;
          end else if (phase == PH_AWAIT_DISC && ok_disc) begin
            phase_next = PH_DONE;
          end
        end
      end
      MODE_TICK: begin
        if (waiting) begin
          if (timed_out) begin
            in_frame_next   = 1'b0;
            body_count_next = 3'd0;
            wait_count_next = 16'd0;
          end else begin
            wait_count_next = wait_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (mode_t'(item.mode))
      MODE_START: send = !waiting;
      MODE_RX:    send = in_frame && is_flag && waiting;
      MODE_TICK:  send = waiting && timed_out;
      default:    send = 1'b0;
    endcase
    job.is_frame = send;
    job.phase    = phase_next;
    case (phase_next)
      PH_AWAIT_DISC: begin
        job.addr = ADDR_SND_TO_RCV;
        job.ctrl = CTRL_DISC;
      end
      PH_DONE: begin
        job.addr = ADDR_RCV_TO_SND;
        job.ctrl = CTRL_UA;
      end
      default: begin
        job.addr = ADDR_SND_TO_RCV;
        job.ctrl = CTRL_SET;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      in_frame   <= 1'b0;
      body_count <= 3'd0;
      rx_address <= 8'd0;
      rx_control <= 8'd0;
      rx_check   <= 8'd0;
      wait_count <= 16'd0;
    end else if (accept) begin
      phase      <= phase_next;
      in_frame   <= in_frame_next;
      body_count <= body_count_next;
      rx_address <= rx_address_next;
      rx_control <= rx_control_next;
      rx_check   <= rx_check_next;
      wait_count <= wait_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg.valid) begin
      timeout_ticks <= cfg.timeout_ticks;
    end
  end

  lsts_frame_tx u_frame_tx (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .job_in (job),
    .take   (take),
    .result (result)
  );

endmodule

### rtl/lsts_frame_tx.sv
module lsts_frame_tx
  import lsts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  tx_job_t job_in,
  output logic    take,
  lsts_out_if.source result
);

  tx_job_t          job;
  logic             busy;
  logic [IDX_W-1:0] idx;
  logic             is_last;
  logic             xfer;

  assign is_last = !job.is_frame || (idx == IDX_W'(FRAME_LEN - 1));
  assign xfer    = busy && result.ready;
  assign take    = !busy || (xfer && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (xfer) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= job_in;
    end
  end

  always_comb begin
    result.tx_byte = 8'd0;
    if (job.is_frame) begin
      case (idx)
        3'd0:    result.tx_byte = FLAG_BYTE;
        3'd1:    result.tx_byte = job.addr;
        3'd2:    result.tx_byte = job.ctrl;
        3'd3:    result.tx_byte = job.addr ^ job.ctrl;
        3'd4:    result.tx_byte = FLAG_BYTE;
        default: result.tx_byte = 8'd0;
      endcase
    end
  end

  assign result.valid    = busy;
  assign result.tx_valid = job.is_frame;
  assign result.last     = is_last;
  assign result.phase    = job.phase;

endmodule

### rtl/lsts_checker.sv
`include "link_setup_teardown_sender_defines.svh"

module lsts_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic       result_tx_valid,
  input logic [7:0] result_tx_byte,
  input logic       result_last,
  input logic [1:0] result_phase
);

  `LSTS_ASSERT_SAME(a_quiet_is_single, result_valid && !result_tx_valid, result_last && result_tx_byte == 8'd0, "result without a byte must be a lone zero result")
  `LSTS_ASSERT_SAME(a_no_take_mid_frame, result_valid && result_tx_valid && !result_last, !item_ready, "item taken before frame finished")
  `LSTS_ASSERT_NEXT(a_frame_continues, result_valid && result_ready && !result_last, result_valid && result_tx_valid && result_phase == $past(result_phase), "frame broken or phase changed mid frame")
  `LSTS_ASSERT_NEXT(a_stall_holds, result_valid && !result_ready, result_valid && $stable(result_tx_byte) && $stable(result_last), "stalled result changed")

endmodule

bind link_setup_teardown_sender lsts_checker u_lsts_checker (
  .clk             (clk),
  .rst             (rst),
  .item_ready      (item.ready),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .result_tx_valid (result.tx_valid),
  .result_tx_byte  (result.tx_byte),
  .result_last     (result.last),
  .result_phase    (result.phase)
);
